// ===== sv/twrsm_pkg.sv =====
package twrsm_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [5:0] LastPhase  = 6'd32;
  localparam logic [5:0] CmdEndPhase = 6'd15;
  localparam logic [5:0] RxStartPhase = 6'd16;

  typedef enum logic {
    FuncRead  = 1'b0,
    FuncWrite = 1'b1
  } func_e;

  typedef struct packed {
    logic       start;
    logic       read_mode;
    logic [7:0] cmd;
    logic [7:0] wdat;
    logic       line;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       done;
    logic       busy;
    logic       line_drive;
    logic       line_out;
    logic       serial_clock;
    logic       chip_enable;
  } res_t;

endpackage

// ===== sv/twrsm_front.sv =====
module twrsm_front (
  input  logic              start_req_i,
  input  logic              func_i,
  input  logic [5:0]        reg_addr_i,
  input  logic [7:0]        write_data_i,
  input  logic              line_in_i,
  output twrsm_pkg::item_t  item_o
);

  logic rd;

  // command byte: bit 7 set, address in bits 6..1, bit 0 marks a read
  assign rd = (twrsm_pkg::func_e'(func_i) == twrsm_pkg::FuncRead);

  always_comb begin
    item_o.start     = start_req_i;
    item_o.read_mode = rd;
    item_o.cmd       = {1'b1, reg_addr_i, rd};
    item_o.wdat      = write_data_i;
    item_o.line      = line_in_i;
  end

endmodule

// ===== sv/twrsm_fifo.sv =====
module twrsm_fifo #(
  parameter int unsigned Depth = twrsm_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  twrsm_pkg::item_t  push_item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output twrsm_pkg::item_t  pop_item_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  twrsm_pkg::item_t mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== sv/twrsm_back.sv =====
module twrsm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  twrsm_pkg::item_t  item_i,
  output logic              pop_o,
  output logic              res_valid_o,
  output twrsm_pkg::res_t   res_o,
  input  logic              res_ready_i
);

  logic [5:0] phase_q, phase_d;
  logic [7:0] tx_q, tx_d;
  logic [7:0] hold_q, hold_d;
  logic       active_q, active_d;
  logic       rd_q, rd_d;
  logic [7:0] rx_q, rx_d;

  logic             out_valid_q;
  twrsm_pkg::res_t  out_q;
  twrsm_pkg::res_t  res;
  logic             advance;

  logic       act;
  logic [5:0] p;
  logic [7:0] tx_e, hold_e, rx_e;
  logic       rd_e;

  assign advance     = valid_i && (!out_valid_q || res_ready_i);
  assign pop_o       = advance;
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    act    = active_q;
    p      = phase_q;
    tx_e   = tx_q;
    hold_e = hold_q;
    rx_e   = rx_q;
    rd_e   = rd_q;
    // latch a new access only while idle
    if (!active_q && item_i.start) begin
      act    = 1'b1;
      p      = '0;
      tx_e   = item_i.cmd;
      hold_e = item_i.wdat;
      rx_e   = '0;
      rd_e   = item_i.read_mode;
    end

    phase_d  = p;
    tx_d     = tx_e;
    hold_d   = hold_e;
    rx_d     = rx_e;
    rd_d     = rd_e;
    active_d = act;

    res.chip_enable  = 1'b0;
    res.serial_clock = 1'b0;
    res.line_out     = 1'b1;
    res.line_drive   = 1'b0;
    res.busy         = 1'b0;
    res.done         = 1'b0;
    res.read_data    = '0;

    if (act) begin
      if (p < twrsm_pkg::LastPhase) begin
        res.chip_enable  = 1'b1;
        res.busy         = 1'b1;
        res.serial_clock = p[0];
        if (p < twrsm_pkg::RxStartPhase || !rd_e) begin
          res.line_drive = 1'b1;
          res.line_out   = tx_e[0];
        end else if (!p[0]) begin
          rx_d[p[3:1]] = rx_e[p[3:1]] | item_i.line;
        end
        if (p[0]) begin
          tx_d = (p == twrsm_pkg::CmdEndPhase) ? hold_e : {1'b0, tx_e[7:1]};
        end
        phase_d = p + 1'b1;
      end else begin
        res.done      = 1'b1;
        res.read_data = rd_e ? rx_e : '0;
        active_d      = 1'b0;
        phase_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      tx_q        <= '0;
      hold_q      <= '0;
      active_q    <= 1'b0;
      rd_q        <= 1'b0;
      rx_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        phase_q  <= phase_d;
        tx_q     <= tx_d;
        hold_q   <= hold_d;
        active_q <= active_d;
        rd_q     <= rd_d;
        rx_q     <= rx_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

endmodule

// ===== sv/three_wire_rtc_serial_master_unit.sv =====
// channel   | dir | signals                          | contents
// ----------+-----+----------------------------------+-------------------------------
// s_axis    | in  | s_axis_tvalid/tready/tdata/tuser | one half-bit tick request
// m_axis    | out | m_axis_tvalid/tready/tdata/tlast | pin levels and status per tick
//
// one tick per clock cycle while m_axis_tready keeps up; a tick passes the front, a queue of
// QueueDepth entries and the back, which registers its result: an accepted tick is written
// into the queue, then popped into the back's result register when nothing stalls.
// reset empties the queue and returns the serial engine to idle.
// a stall on the master side fills the queue, then drops s_axis_tready.
module three_wire_rtc_serial_master_unit #(
  parameter int unsigned QueueDepth = twrsm_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // start_req[0], reg_addr[6:1], write_data[14:7], line_in[15]
  input  logic [15:0] s_axis_tdata,
  // func[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // chip_enable[0], serial_clock[1], line_out[2], line_drive[3], busy_res[4],
  // read_data[12:5], zero[15:13]
  output logic [15:0] m_axis_tdata,
  // done_res
  output logic        m_axis_tlast
);

  twrsm_pkg::item_t in_item;
  twrsm_pkg::item_t q_item;
  twrsm_pkg::res_t  res;
  logic             full;
  logic             q_valid;
  logic             pop;

  twrsm_front u_front (
    .start_req_i  (s_axis_tdata[0]),
    .func_i       (s_axis_tuser),
    .reg_addr_i   (s_axis_tdata[6:1]),
    .write_data_i (s_axis_tdata[14:7]),
    .line_in_i    (s_axis_tdata[15]),
    .item_o       (in_item)
  );

  twrsm_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_item_i (in_item),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (q_item)
  );

  twrsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid),
    .res_o       (res),
    .res_ready_i (m_axis_tready)
  );

  assign s_axis_tready = !full;
  assign m_axis_tdata  = {3'b000, res.read_data, res.busy, res.line_drive,
                          res.line_out, res.serial_clock, res.chip_enable};
  assign m_axis_tlast  = res.done;

endmodule

// ===== dv/tb_three_wire_rtc_serial_master_unit.sv =====
module tb_three_wire_rtc_serial_master_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom  = 385;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 300;

  typedef struct packed {
    logic               line;
    logic [7:0]         wdat;
    logic [5:0]         addr;
    twrsm_pkg::func_e   func;
    logic               start;
  } tick_in_t;

  typedef struct {
    tick_in_t         stim;
    bit               typed;
    twrsm_pkg::res_t  want;
  } dir_row_t;

  localparam twrsm_pkg::res_t IdlePins = '{read_data: 8'h00, done: 1'b0, busy: 1'b0,
                                           line_drive: 1'b0, line_out: 1'b1,
                                           serial_clock: 1'b0, chip_enable: 1'b0};
  localparam twrsm_pkg::res_t CmdLowPins = '{read_data: 8'h00, done: 1'b0, busy: 1'b1,
                                             line_drive: 1'b1, line_out: 1'b1,
                                             serial_clock: 1'b0, chip_enable: 1'b1};
  localparam twrsm_pkg::res_t CmdHighPins = '{read_data: 8'h00, done: 1'b0, busy: 1'b1,
                                              line_drive: 1'b1, line_out: 1'b1,
                                              serial_clock: 1'b1, chip_enable: 1'b1};

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  three_wire_rtc_serial_master_unit dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast
  );

  // serial engine mirror
  logic [5:0] phase_q;
  logic [7:0] tx_sr;
  logic [7:0] wr_byte;
  logic [7:0] rx_sr;
  logic       access_on;
  logic       is_read;

  twrsm_pkg::res_t pin_queue[$];
  int              mismatches = 0;
  int unsigned     cycles = 0;
  dir_row_t        dir_rows[$];
  bit              tx_steady;
  int              line_mode;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic twrsm_pkg::res_t tick_pins(tick_in_t t);
    twrsm_pkg::res_t r;
    logic [5:0]      p;
    r = IdlePins;
    if (!access_on && t.start) begin
      access_on = 1'b1;
      is_read   = (t.func == twrsm_pkg::FuncRead);
      tx_sr     = {1'b1, t.addr, is_read};
      wr_byte   = t.wdat;
      rx_sr     = 8'h00;
      phase_q   = 6'd0;
    end
    if (access_on) begin
      p = phase_q;
      if (p < twrsm_pkg::LastPhase) begin
        r.chip_enable  = 1'b1;
        r.busy         = 1'b1;
        r.serial_clock = p[0];
        if (p < twrsm_pkg::RxStartPhase || !is_read) begin
          r.line_drive = 1'b1;
          r.line_out   = tx_sr[0];
        end else if (!p[0]) begin
          rx_sr = rx_sr | (8'(t.line) << p[3:1]);
        end
        if (p[0]) begin
          tx_sr = (p == twrsm_pkg::CmdEndPhase) ? wr_byte : (tx_sr >> 1);
        end
        phase_q = p + 6'd1;
      end else begin
        r.done      = 1'b1;
        r.read_data = is_read ? rx_sr : 8'h00;
        access_on   = 1'b0;
        phase_q     = 6'd0;
      end
    end
    return r;
  endfunction

  task automatic send_tick(tick_in_t t, bit typed, twrsm_pkg::res_t want);
    int              gap;
    twrsm_pkg::res_t pred;
    if ($urandom_range(0, 19) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t.line, t.wdat, t.addr, t.start};
    s_axis_tuser  <= t.func;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = tick_pins(t);
    pin_queue.push_back(typed ? want : pred);
  endtask

  function automatic tick_in_t rand_tick();
    tick_in_t t;
    if ($urandom_range(0, 39) == 0) line_mode = $urandom_range(0, 2);
    t.start = ($urandom_range(0, 2) == 0);
    t.func  = twrsm_pkg::func_e'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: t.addr = 6'd0;
      1: t.addr = 6'd63;
      default: t.addr = 6'($urandom_range(0, 63));
    endcase
    case ($urandom_range(0, 5))
      0: t.wdat = 8'h00;
      1: t.wdat = 8'hFF;
      default: t.wdat = 8'($urandom_range(0, 255));
    endcase
    case (line_mode)
      1: t.line = 1'b1;
      2: t.line = 1'b0;
      default: t.line = 1'($urandom_range(0, 1));
    endcase
    return t;
  endfunction

  function automatic void cmp_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result side
  always @(posedge clk_i) begin
    twrsm_pkg::res_t got;
    twrsm_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{read_data: m_axis_tdata[12:5], done: m_axis_tlast, busy: m_axis_tdata[4],
              line_drive: m_axis_tdata[3], line_out: m_axis_tdata[2],
              serial_clock: m_axis_tdata[1], chip_enable: m_axis_tdata[0]};
      if (pin_queue.size() == 0) begin
        $display("%0t: unexpected transaction, expected none got %h %b", $time,
                 m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = pin_queue.pop_front();
        cmp_field("chip_enable", want.chip_enable, got.chip_enable);
        cmp_field("serial_clock", want.serial_clock, got.serial_clock);
        cmp_field("line_out", want.line_out, got.line_out);
        cmp_field("line_drive", want.line_drive, got.line_drive);
        cmp_field("busy", want.busy, got.busy);
        cmp_field("done", want.done, got.done);
        cmp_field("read_data", want.read_data, got.read_data);
        cmp_field("pad", 0, m_axis_tdata[15:13]);
      end
    end
  end

  // receiver stalls
  initial begin
    int unsigned taken;
    int          gap;
    bit          rx_steady;
    bit          held;
    taken         = 0;
    rx_steady     = 1'b0;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_steady = !rx_steady;
      gap = rx_steady ? 0 : $urandom_range(0, 11);
      if (!held && taken >= 120) begin
        held = 1'b1;
        gap  = LongHold;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      taken++;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    tx_steady     = 1'b0;
    line_mode     = 0;
    phase_q       = 6'd0;
    tx_sr         = 8'h00;
    wr_byte       = 8'h00;
    rx_sr         = 8'h00;
    access_on     = 1'b0;
    is_read       = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;

    // idle tick, then a read of the top register with requests arriving while busy
    dir_rows.push_back('{'{line: 1'b1, wdat: 8'hFF, addr: 6'd63,
                           func: twrsm_pkg::FuncWrite, start: 1'b0},
                        1'b1, IdlePins});
    dir_rows.push_back('{'{line: 1'b0, wdat: 8'h00, addr: 6'd63,
                           func: twrsm_pkg::FuncRead, start: 1'b1},
                        1'b1, CmdLowPins});
    dir_rows.push_back('{'{line: 1'b1, wdat: 8'hFF, addr: 6'd0,
                           func: twrsm_pkg::FuncWrite, start: 1'b1},
                        1'b1, CmdHighPins});
    dir_rows.push_back('{'{line: 1'b0, wdat: 8'h00, addr: 6'd0,
                           func: twrsm_pkg::FuncRead, start: 1'b1},
                        1'b0, IdlePins});
    dir_rows.push_back('{'{line: 1'b1, wdat: 8'hA5, addr: 6'd32,
                           func: twrsm_pkg::FuncWrite, start: 1'b0},
                        1'b0, IdlePins});
    dir_rows.push_back('{'{line: 1'b0, wdat: 8'h5A, addr: 6'd31,
                           func: twrsm_pkg::FuncRead, start: 1'b1},
                        1'b0, IdlePins});
    dir_rows.push_back('{'{line: 1'b1, wdat: 8'h01, addr: 6'd1,
                           func: twrsm_pkg::FuncWrite, start: 1'b0},
                        1'b0, IdlePins});
    dir_rows.push_back('{'{line: 1'b0, wdat: 8'h80, addr: 6'd62,
                           func: twrsm_pkg::FuncRead, start: 1'b0},
                        1'b0, IdlePins});
    dir_rows.push_back('{'{line: 1'b1, wdat: 8'h7F, addr: 6'd21,
                           func: twrsm_pkg::FuncWrite, start: 1'b1},
                        1'b0, IdlePins});
    dir_rows.push_back('{'{line: 1'b0, wdat: 8'hFE, addr: 6'd42,
                           func: twrsm_pkg::FuncRead, start: 1'b0},
                        1'b0, IdlePins});
    dir_rows.push_back('{'{line: 1'b1, wdat: 8'h33, addr: 6'd16,
                           func: twrsm_pkg::FuncWrite, start: 1'b0},
                        1'b0, IdlePins});
    dir_rows.push_back('{'{line: 1'b0, wdat: 8'hCC, addr: 6'd47,
                           func: twrsm_pkg::FuncRead, start: 1'b1},
                        1'b0, IdlePins});
    dir_rows.push_back('{'{line: 1'b1, wdat: 8'h0F, addr: 6'd8,
                           func: twrsm_pkg::FuncWrite, start: 1'b0},
                        1'b0, IdlePins});
    dir_rows.push_back('{'{line: 1'b1, wdat: 8'hF0, addr: 6'd55,
                           func: twrsm_pkg::FuncRead, start: 1'b0},
                        1'b0, IdlePins});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_tick(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    for (int i = 0; i < NumRandom; i++) send_tick(rand_tick(), 1'b0, IdlePins);
    s_axis_tvalid <= 1'b0;

    wait (pin_queue.size() == 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
